@@ hw/rtl/smbs_pkg.sv @@
// Shared types and constants for the SPI master byte shifter.
// No dependencies; every other file of the block imports this package.
package smbs_pkg;

   // Default word length of one transfer
   localparam int BITS_PER_WORD_DEFAULT = 8;

   // Width of the external byte fields and the divider
   localparam int BYTE_WIDTH = 8;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CLOCK_POLARITY    = 2'd0,
      CSR_CLOCK_PHASE       = 2'd1,
      CSR_LSB_FIRST         = 2'd2,
      CSR_HALF_PERIOD_TICKS = 2'd3
   } csr_index_type;

   // Item kinds on the request channel
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   // Reset value of the half period register
   localparam logic [BYTE_WIDTH-1:0] HALF_PERIOD_RESET = 8'd1;

   // Configuration as seen by the shifter core
   typedef struct packed {
      logic                  clock_polarity;
      logic                  clock_phase;
      logic                  lsb_first;
      logic [BYTE_WIDTH-1:0] half_period_ticks;
   } cfg_type;

   // One request item
   typedef struct packed {
      logic                  req_type;
      logic [BYTE_WIDTH-1:0] tx_byte;
      logic                  miso_in;
   } item_type;

   // One result item
   typedef struct packed {
      logic                  sck_out;
      logic                  mosi_out;
      logic                  select_n;
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  done_res;
      logic                  busy_res;
   } result_type;

endpackage

@@ hw/rtl/smbs_csr.sv @@
// Configuration registers of the SPI master byte shifter.
// Depends on smbs_pkg for the register index codes and the cfg_type struct.
module smbs_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [smbs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [smbs_pkg::BYTE_WIDTH-1:0]         csr_write_data,
   output smbs_pkg::cfg_type                       cfg
);
   import smbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLOCK_POLARITY:    cfg_in.clock_polarity    = csr_write_data[0];
            CSR_CLOCK_PHASE:       cfg_in.clock_phase       = csr_write_data[0];
            CSR_LSB_FIRST:         cfg_in.lsb_first         = csr_write_data[0];
            CSR_HALF_PERIOD_TICKS: cfg_in.half_period_ticks = csr_write_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clock_polarity    <= 1'b0;
         cfg_ff.clock_phase       <= 1'b0;
         cfg_ff.lsb_first         <= 1'b0;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ hw/rtl/smbs_core.sv @@
// Transfer state and per-item update logic of the SPI master byte shifter.
// Depends on smbs_pkg for the item, result and configuration structs.
module smbs_core #(
   parameter int BITS_PER_WORD = smbs_pkg::BITS_PER_WORD_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  smbs_pkg::item_type    item,
   input  smbs_pkg::cfg_type     cfg,
   output smbs_pkg::result_type  result
);
   import smbs_pkg::*;

   localparam int COUNT_WIDTH = $clog2(BITS_PER_WORD + 1);
   localparam logic [COUNT_WIDTH-1:0] BITS_FULL = COUNT_WIDTH'(BITS_PER_WORD);

   logic [BITS_PER_WORD-1:0] tx_shift_ff, tx_shift_in;
   logic [BITS_PER_WORD-1:0] rx_shift_ff, rx_shift_in;
   logic [COUNT_WIDTH-1:0]   bits_left_ff, bits_left_in;
   logic                     half_phase_ff, half_phase_in;
   logic [BYTE_WIDTH-1:0]    divider_count_ff, divider_count_in;
   logic                     active_ff, active_in;
   logic                     clock_level_ff, clock_level_in;

   logic [BYTE_WIDTH-1:0]    half_period;
   logic [BYTE_WIDTH-1:0]    divider_next;
   logic [BITS_PER_WORD-1:0] tx_word;
   logic [BYTE_WIDTH-1:0]    rx_low;
   logic                     done;
   logic                     sample;

   // Fit the transmit byte into the word and the word into the receive byte
   always_comb begin
      for (int i = 0; i < BITS_PER_WORD; i++) begin
         tx_word[i] = (i < BYTE_WIDTH) ? item.tx_byte[i % BYTE_WIDTH] : 1'b0;
      end
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         rx_low[i] = (i < BITS_PER_WORD) ? rx_shift_in[i % BITS_PER_WORD] : 1'b0;
      end
   end

   // Advance the transfer by one item
   always_comb begin
      tx_shift_in      = tx_shift_ff;
      rx_shift_in      = rx_shift_ff;
      bits_left_in     = bits_left_ff;
      half_phase_in    = half_phase_ff;
      divider_count_in = divider_count_ff;
      active_in        = active_ff;
      clock_level_in   = clock_level_ff;
      done             = 1'b0;
      sample           = 1'b0;
      half_period      = (cfg.half_period_ticks == '0) ? HALF_PERIOD_RESET
                                                       : cfg.half_period_ticks;
      divider_next     = divider_count_ff + 8'd1;

      if (step_en) begin
         if (item.req_type == REQ_START) begin
            // Load a new word unless a transfer is running
            if (!active_ff) begin
               tx_shift_in      = tx_word;
               rx_shift_in      = '0;
               bits_left_in     = BITS_FULL;
               half_phase_in    = 1'b0;
               divider_count_in = '0;
               active_in        = 1'b1;
               clock_level_in   = cfg.clock_polarity;
            end
         end else if (active_ff) begin
            divider_count_in = divider_next;
            if (divider_next >= half_period) begin
               divider_count_in = '0;
               clock_level_in   = ~clock_level_ff;
               if (!half_phase_ff) begin
                  // Leading edge
                  half_phase_in = 1'b1;
                  if (!cfg.clock_phase) begin
                     sample = 1'b1;
                  end else if (bits_left_ff != BITS_FULL) begin
                     tx_shift_in = cfg.lsb_first ? (tx_shift_ff >> 1) : (tx_shift_ff << 1);
                  end
               end else begin
                  // Trailing edge
                  half_phase_in = 1'b0;
                  if (cfg.clock_phase) begin
                     sample = 1'b1;
                  end else if (bits_left_ff > COUNT_WIDTH'(1)) begin
                     tx_shift_in = cfg.lsb_first ? (tx_shift_ff >> 1) : (tx_shift_ff << 1);
                  end
                  if (bits_left_ff != '0) begin
                     bits_left_in = bits_left_ff - COUNT_WIDTH'(1);
                  end
                  if (bits_left_in == '0) begin
                     active_in      = 1'b0;
                     done           = 1'b1;
                     clock_level_in = cfg.clock_polarity;
                  end
               end
               // Shift the slave line into the receive word
               if (sample) begin
                  rx_shift_in = cfg.lsb_first
                     ? {item.miso_in, rx_shift_ff[BITS_PER_WORD-1:1]}
                     : {rx_shift_ff[BITS_PER_WORD-2:0], item.miso_in};
               end
            end
         end
      end
   end

   // Drive the line levels from the updated state
   always_comb begin
      if (active_in) begin
         result.sck_out  = clock_level_in;
         result.mosi_out = cfg.lsb_first ? tx_shift_in[0] : tx_shift_in[BITS_PER_WORD-1];
         result.select_n = 1'b0;
         result.busy_res = 1'b1;
      end else begin
         result.sck_out  = cfg.clock_polarity;
         result.mosi_out = 1'b0;
         result.select_n = 1'b1;
         result.busy_res = 1'b0;
      end
      result.rx_byte  = done ? rx_low : '0;
      result.done_res = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff      <= '0;
         rx_shift_ff      <= '0;
         bits_left_ff     <= '0;
         half_phase_ff    <= 1'b0;
         divider_count_ff <= '0;
         active_ff        <= 1'b0;
         clock_level_ff   <= 1'b0;
      end else begin
         tx_shift_ff      <= tx_shift_in;
         rx_shift_ff      <= rx_shift_in;
         bits_left_ff     <= bits_left_in;
         half_phase_ff    <= half_phase_in;
         divider_count_ff <= divider_count_in;
         active_ff        <= active_in;
         clock_level_ff   <= clock_level_in;
      end
   end

   // A running transfer always has bits left to move
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (bits_left_ff != '0 && bits_left_ff <= BITS_FULL))
      else $error("active transfer with bad bit count");

   // An idle shifter keeps its divider cleared
   assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (divider_count_ff == '0))
      else $error("divider not cleared while idle");

   // Done only on the trailing edge of the last bit
   assert property (@(posedge clock) disable iff (reset)
      (step_en && result.done_res) |-> (active_ff && half_phase_ff && !active_in))
      else $error("done outside a trailing edge");

endmodule

@@ hw/rtl/smbs_out_reg.sv @@
// Result register of the SPI master byte shifter: holds one result item
// until the consumer takes it. Depends on smbs_pkg for result_type.
module smbs_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  smbs_pkg::result_type  result,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output smbs_pkg::result_type  rsp_data
);
   import smbs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Take a new result when empty or when the held one leaves this cycle
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

@@ hw/rtl/spi_master_byte_shifter.sv @@
// SPI master byte shifter. Each request item is a start (loads the word, drops
// select) or a tick of time carrying the sampled MISO level; every item gives
// exactly one result with SCK, MOSI, select, busy, and on the item that ends the
// last bit the received byte with done set. One item is taken every cycle while
// the result register has room; a result leaves through an input register and a
// result register with the whole update between them. SCK toggles every
// half_period_ticks tick items (zero acts as one). A start while busy is ignored.
// Depends on smbs_pkg, smbs_csr, smbs_core and smbs_out_reg.
module spi_master_byte_shifter #(
   parameter int BITS_PER_WORD = smbs_pkg::BITS_PER_WORD_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [smbs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [smbs_pkg::BYTE_WIDTH-1:0]      csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_type,
   input  logic [smbs_pkg::BYTE_WIDTH-1:0]      req_tx_byte,
   input  logic                                 req_miso_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_sck_out,
   output logic                                 rsp_mosi_out,
   output logic                                 rsp_select_n,
   output logic [smbs_pkg::BYTE_WIDTH-1:0]      rsp_rx_byte,
   output logic                                 rsp_done_res,
   output logic                                 rsp_busy_res
);
   import smbs_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   logic       out_free;
   logic       advance;
   result_type result;
   result_type rsp_data;

   smbs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Move the held item into the core when the result register has room
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      item_in     = item_ff;
      if (req_valid && req_ready) begin
         in_valid_in      = 1'b1;
         item_in.req_type = req_type;
         item_in.tx_byte  = req_tx_byte;
         item_in.miso_in  = req_miso_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   smbs_core #(
      .BITS_PER_WORD (BITS_PER_WORD)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   smbs_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_sck_out  = rsp_data.sck_out;
   assign rsp_mosi_out = rsp_data.mosi_out;
   assign rsp_select_n = rsp_data.select_n;
   assign rsp_rx_byte  = rsp_data.rx_byte;
   assign rsp_done_res = rsp_data.done_res;
   assign rsp_busy_res = rsp_data.busy_res;

   // Select is low exactly while busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_select_n == !rsp_busy_res))
      else $error("select and busy disagree");

   // A done item closes the transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res) |-> (!rsp_busy_res && rsp_select_n && !rsp_mosi_out))
      else $error("done item with transfer still open");

   // Outside a transfer the data line rests low and no byte is shown
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_busy_res && !rsp_done_res) |-> (!rsp_mosi_out && rsp_rx_byte == '0))
      else $error("idle result drives data");

endmodule

@@ test/smbs_line_checker.sv @@
// Line state checker for the SPI master byte shifter: watches the register port
// and both item channels, predicts every result item and compares it in order.
// Depends on smbs_pkg for the item, result and register index types.
module smbs_line_checker
   import smbs_pkg::*;
#(
   parameter int WORD_BITS = BITS_PER_WORD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [BYTE_WIDTH-1:0]      csr_write_data,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic                       req_type,
   input  logic [BYTE_WIDTH-1:0]      req_tx_byte,
   input  logic                       req_miso_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       rsp_sck_out,
   input  logic                       rsp_mosi_out,
   input  logic                       rsp_select_n,
   input  logic [BYTE_WIDTH-1:0]      rsp_rx_byte,
   input  logic                       rsp_done_res,
   input  logic                       rsp_busy_res,
   output int                         fail_count,
   output int                         pending_results,
   output int                         results_checked,
   output int                         transfers_done
);

   // Shadow of the register file
   cfg_type cfg;

   // Shadow of the shifter state
   logic [WORD_BITS-1:0]  tx_word;
   logic [WORD_BITS-1:0]  rx_word;
   int                    bits_remaining;
   logic                  second_half;
   logic [BYTE_WIDTH-1:0] tick_count;
   logic                  xfer_active;
   logic                  sck_level;

   // Line states still owed by the block, oldest first
   result_type expected_line_states[$];

   int mismatches;
   int checked;
   int completed;

   // Move the transmit word on by one bit
   function automatic void advance_tx();
      if (cfg.lsb_first) begin
         tx_word = tx_word >> 1;
      end else begin
         tx_word = tx_word << 1;
      end
   endfunction

   // Shift the sampled slave level into the receive word
   function automatic void capture_miso(input logic level);
      if (cfg.lsb_first) begin
         rx_word = {level, rx_word[WORD_BITS-1:1]};
      end else begin
         rx_word = {rx_word[WORD_BITS-2:0], level};
      end
   endfunction

   // Advance the shifter by one item and return the line levels it shows
   function automatic result_type spi_shift_step(input item_type it);
      result_type            lines;
      logic [BYTE_WIDTH-1:0] half_eff;
      logic                  finished;
      logic [BYTE_WIDTH-1:0] rx_done;
      half_eff = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;
      finished = 1'b0;
      rx_done  = '0;
      if (it.req_type == REQ_START) begin
         // load a new word unless a transfer is already running
         if (!xfer_active) begin
            tx_word        = WORD_BITS'(it.tx_byte);
            rx_word        = '0;
            bits_remaining = WORD_BITS;
            second_half    = 1'b0;
            tick_count     = '0;
            xfer_active    = 1'b1;
            sck_level      = cfg.clock_polarity;
         end
      end else if (xfer_active) begin
         tick_count = tick_count + 8'd1;
         if (tick_count >= half_eff) begin
            tick_count = '0;
            sck_level  = ~sck_level;
            if (!second_half) begin
               // leading edge: sample in phase 0, move on in phase 1 past the first bit
               second_half = 1'b1;
               if (!cfg.clock_phase) begin
                  capture_miso(it.miso_in);
               end else if (bits_remaining != WORD_BITS) begin
                  advance_tx();
               end
            end else begin
               // trailing edge: sample in phase 1, move on in phase 0 before the last bit
               second_half = 1'b0;
               if (cfg.clock_phase) begin
                  capture_miso(it.miso_in);
               end else if (bits_remaining > 1) begin
                  advance_tx();
               end
               if (bits_remaining > 0) begin
                  bits_remaining--;
               end
               if (bits_remaining == 0) begin
                  xfer_active = 1'b0;
                  finished    = 1'b1;
                  rx_done     = BYTE_WIDTH'(rx_word);
                  sck_level   = cfg.clock_polarity;
               end
            end
         end
      end

      if (xfer_active) begin
         lines.sck_out  = sck_level;
         lines.mosi_out = cfg.lsb_first ? tx_word[0] : tx_word[WORD_BITS-1];
         lines.select_n = 1'b0;
         lines.busy_res = 1'b1;
      end else begin
         lines.sck_out  = cfg.clock_polarity;
         lines.mosi_out = 1'b0;
         lines.select_n = 1'b1;
         lines.busy_res = 1'b0;
      end
      lines.rx_byte  = rx_done;
      lines.done_res = finished;
      return lines;
   endfunction

   always @(posedge clock) begin : track
      item_type   taken;
      result_type seen;
      result_type want;
      if (reset) begin
         cfg.clock_polarity    = 1'b0;
         cfg.clock_phase       = 1'b0;
         cfg.lsb_first         = 1'b0;
         cfg.half_period_ticks = HALF_PERIOD_RESET;
         tx_word        = '0;
         rx_word        = '0;
         bits_remaining = 0;
         second_half    = 1'b0;
         tick_count     = '0;
         xfer_active    = 1'b0;
         sck_level      = 1'b0;
         expected_line_states.delete();
      end else begin
         // apply a register write
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_CLOCK_POLARITY:    cfg.clock_polarity    = csr_write_data[0];
               CSR_CLOCK_PHASE:       cfg.clock_phase       = csr_write_data[0];
               CSR_LSB_FIRST:         cfg.lsb_first         = csr_write_data[0];
               CSR_HALF_PERIOD_TICKS: cfg.half_period_ticks = csr_write_data;
               default: ;
            endcase
         end

         // check a result item against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            seen = '{sck_out: rsp_sck_out, mosi_out: rsp_mosi_out,
                     select_n: rsp_select_n, rx_byte: rsp_rx_byte,
                     done_res: rsp_done_res, busy_res: rsp_busy_res};
            if (expected_line_states.size() == 0) begin
               if (mismatches < 200) begin
                  $display("%0t: result item with none expected: sck=%b mosi=%b cs_n=%b rx=%h done=%b busy=%b",
                           $time, seen.sck_out, seen.mosi_out, seen.select_n,
                           seen.rx_byte, seen.done_res, seen.busy_res);
               end
               mismatches++;
            end else begin
               want = expected_line_states.pop_front();
               checked++;
               if (seen !== want) begin
                  if (mismatches < 200) begin
                     $display("%0t: mismatch expected sck=%b mosi=%b cs_n=%b rx=%h done=%b busy=%b",
                              $time, want.sck_out, want.mosi_out, want.select_n,
                              want.rx_byte, want.done_res, want.busy_res);
                     $display("%0t:          actual   sck=%b mosi=%b cs_n=%b rx=%h done=%b busy=%b",
                              $time, seen.sck_out, seen.mosi_out, seen.select_n,
                              seen.rx_byte, seen.done_res, seen.busy_res);
                  end
                  mismatches++;
               end
            end
         end

         // predict the result of an accepted item
         if (req_valid && req_ready) begin
            taken.req_type = req_type;
            taken.tx_byte  = req_tx_byte;
            taken.miso_in  = req_miso_in;
            want = spi_shift_step(taken);
            if (want.done_res) begin
               completed++;
            end
            expected_line_states.push_back(want);
         end
      end

      fail_count      <= mismatches;
      pending_results <= expected_line_states.size();
      results_checked <= checked;
      transfers_done  <= completed;
   end

   initial begin
      mismatches      = 0;
      checked         = 0;
      completed       = 0;
      fail_count      = 0;
      pending_results = 0;
      results_checked = 0;
      transfers_done  = 0;
   end

endmodule

@@ test/spi_master_byte_shifter_tb.sv @@
// Top of the SPI master byte shifter bench: clock, reset, register setup and
// item stimulus with random idling on both channels, plus the final verdict.
// Depends on smbs_pkg, spi_master_byte_shifter and smbs_line_checker.
module spi_master_byte_shifter_tb;
   import smbs_pkg::*;

   localparam int WORD_BITS = BITS_PER_WORD_DEFAULT;

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [BYTE_WIDTH-1:0]      csr_write_data   = '0;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic                       req_type         = REQ_TICK;
   logic [BYTE_WIDTH-1:0]      req_tx_byte      = '0;
   logic                       req_miso_in      = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic                       rsp_sck_out;
   logic                       rsp_mosi_out;
   logic                       rsp_select_n;
   logic [BYTE_WIDTH-1:0]      rsp_rx_byte;
   logic                       rsp_done_res;
   logic                       rsp_busy_res;

   int fail_count;
   int pending_results;
   int results_checked;
   int transfers_done;

   // Idle rates in percent, and the effective half period for transfer lengths
   int req_gap_pct   = 37;
   int rsp_stall_pct = 57;
   int cur_half      = 1;
   int items_sent    = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   spi_master_byte_shifter #(
      .BITS_PER_WORD(WORD_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_tx_byte     (req_tx_byte),
      .req_miso_in     (req_miso_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sck_out     (rsp_sck_out),
      .rsp_mosi_out    (rsp_mosi_out),
      .rsp_select_n    (rsp_select_n),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_done_res    (rsp_done_res),
      .rsp_busy_res    (rsp_busy_res)
   );

   smbs_line_checker #(
      .WORD_BITS(WORD_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_tx_byte     (req_tx_byte),
      .req_miso_in     (req_miso_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sck_out     (rsp_sck_out),
      .rsp_mosi_out    (rsp_mosi_out),
      .rsp_select_n    (rsp_select_n),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_done_res    (rsp_done_res),
      .rsp_busy_res    (rsp_busy_res),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .results_checked (results_checked),
      .transfers_done  (transfers_done)
   );

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Pick a transmit word, favoring all zeros and all ones
   function automatic logic [BYTE_WIDTH-1:0] pick_byte();
      int roll;
      roll = $urandom_range(7);
      if (roll == 0) begin
         return 8'h00;
      end else if (roll == 1) begin
         return 8'hFF;
      end
      return BYTE_WIDTH'($urandom_range(255));
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic kind, input logic [BYTE_WIDTH-1:0] data,
                            input logic miso);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_tx_byte <= data;
      req_miso_in <= miso;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Write all four registers, one per cycle
   task automatic program_csrs(input logic pol, input logic pha, input logic lsb,
                               input logic [BYTE_WIDTH-1:0] half);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_CLOCK_POLARITY;
      csr_write_data   <= {7'd0, pol};
      @(posedge clock);
      csr_index        <= CSR_CLOCK_PHASE;
      csr_write_data   <= {7'd0, pha};
      @(posedge clock);
      csr_index        <= CSR_LSB_FIRST;
      csr_write_data   <= {7'd0, lsb};
      @(posedge clock);
      csr_index        <= CSR_HALF_PERIOD_TICKS;
      csr_write_data   <= half;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_half = (half == 0) ? 1 : half;
   endtask

   // Drop valid, wait for every owed result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Mostly whole transfers with random data; the rest stray or cut short
   task automatic random_traffic(input int n);
      int stop_at;
      int ticks;
      int roll;
      stop_at = items_sent + n;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            send_item(REQ_START, pick_byte(), 1'($urandom_range(1)));
            ticks = 2 * WORD_BITS * cur_half + $urandom_range(2);
            if ($urandom_range(9) == 0) begin
               ticks = $urandom_range(ticks, 1);
            end
            repeat (ticks) begin
               // a start in mid transfer must be ignored
               if ($urandom_range(19) == 0) begin
                  send_item(REQ_START, pick_byte(), 1'($urandom_range(1)));
               end
               send_item(REQ_TICK, BYTE_WIDTH'($urandom_range(255)),
                         1'($urandom_range(1)));
            end
         end else begin
            send_item(roll[0], BYTE_WIDTH'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   // One register setting: drain, set idling, program, then traffic
   task automatic run_phase(input logic pol, input logic pha, input logic lsb,
                            input logic [BYTE_WIDTH-1:0] half,
                            input int gap_pct, input int stall_pct, input int n);
      settle();
      req_gap_pct   <= gap_pct;
      rsp_stall_pct <= stall_pct;
      program_csrs(pol, pha, lsb, half);
      if (half == 8'd255) begin
         // slowest divider: start a word and run to its first serial clock edge;
         // the next setting finishes it with a short period
         send_item(REQ_START, pick_byte(), 1'b0);
         repeat (n) send_item(REQ_TICK, BYTE_WIDTH'($urandom_range(255)),
                              1'($urandom_range(1)));
      end else begin
         random_traffic(n);
      end
   endtask

   // Give up on a hung run
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero half period, all options set, edge words and miso levels
      program_csrs(1'b1, 1'b1, 1'b1, 8'd0);
      send_item(REQ_TICK, 8'hFF, 1'b1);
      send_item(REQ_START, 8'hA5, 1'b0);
      send_item(REQ_START, 8'h5A, 1'b1);
      for (int i = 0; i < 2 * WORD_BITS; i++) begin
         send_item(REQ_TICK, 8'h00, i[1]);
      end
      send_item(REQ_TICK, 8'h00, 1'b0);
      send_item(REQ_START, 8'hFF, 1'b1);
      send_item(REQ_START, 8'h00, 1'b0);

      // Random: the last transfer above is still running into the first setting
      run_phase(1'b0, 1'b0, 1'b0, 8'd1,   37, 57, 30);
      run_phase(1'b1, 1'b0, 1'b1, 8'd2,   37, 57, 30);
      run_phase(1'b0, 1'b1, 1'b0, 8'd3,   57, 37, 30);
      run_phase(1'b0, 1'b0, 1'b1, 8'd255, 57, 37, 256);
      run_phase(1'b1, 1'b1, 1'b0, 8'd1,    0,  0, 30);
      run_phase(1'b0, 1'b1, 1'b1, 8'd4,    0,  0, 30);
      settle();

      $display("Sent %0d request items, checked %0d result items, %0d words completed.",
               items_sent, results_checked, transfers_done);
      $display("Covered all four SPI modes, both bit orders, half periods 0 to 4 and 255, idling on and off.");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/smbs_pkg.sv
hw/rtl/smbs_csr.sv
hw/rtl/smbs_core.sv
hw/rtl/smbs_out_reg.sv
hw/rtl/spi_master_byte_shifter.sv
test/smbs_line_checker.sv
test/spi_master_byte_shifter_tb.sv
